### design/brf_pkg.sv
// Shared types and constants for the boot frame receiver.
// Holds the result record, status and kind codes, and the frame limits.
`default_nettype none

package brf_pkg;

	localparam logic [31:0] FRAME_MAGIC     = 32'h4C42_4B52;
	localparam int          SIZE_W          = 25;
	localparam logic [SIZE_W-1:0] MAX_FRAME_BYTES = 25'd16777216;
	localparam int          HDR_LAST        = 11;

	localparam logic        KIND_WRITE  = 1'b0;
	localparam logic        KIND_STATUS = 1'b1;

	localparam logic [1:0]  ST_OK        = 2'd0;
	localparam logic [1:0]  ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0]  ST_BAD_SIZE  = 2'd2;
	localparam logic [1:0]  ST_BAD_SUM   = 2'd3;

	localparam int          QUEUE_DEPTH = 8;
	localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int          QCNT_W      = QPTR_W + 1;
	localparam int          QUEUE_HIGH  = 4;

	typedef struct packed {
		logic        kind;
		logic [23:0] offset;
		logic [7:0]  data_byte;
		logic [1:0]  status;
		logic [31:0] frame_size;
		logic [31:0] computed_sum;
		logic [31:0] expected_sum;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

### design/boot_frame_receiver.sv
// Boot frame receiver: header assembly, magic and size checks, payload writes, checksum status.
// Depends on brf_pkg for the result record, codes and frame limits.
// An accepted byte is registered in byte_s1 and processed from that register into the result queue;
// its results are offered from the queue head once they are queued.
// Throughput: one byte per cycle while in_stall is low; the eight-entry result queue raises in_stall at four entries.
// Reset clears the header parser, queue pointers and sets max_size to 16777216.
`default_nettype none

module boot_frame_receiver (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           max_size_we,
	input  wire  [brf_pkg::SIZE_W-1:0]    max_size_wdata,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [7:0]                    rx_byte,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          kind,
	output logic [23:0]                   offset,
	output logic [7:0]                    data_byte,
	output logic [1:0]                    status,
	output logic [31:0]                   frame_size,
	output logic [31:0]                   computed_sum,
	output logic [31:0]                   expected_sum,
	output logic                          last
);
	import brf_pkg::*;

	logic [SIZE_W-1:0] max_size_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              in_payload_q;
	logic [3:0]        hdr_count_q;
	logic [31:0]       magic_q;
	logic [31:0]       size_q;
	logic [31:0]       exp_q;
	logic [SIZE_W-1:0] idx_q;
	logic [31:0]       sum_q;

	result_t           queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic              in_acc;
	logic              pop;
	logic [1:0]        push_cnt;
	result_t           res0;
	result_t           res1;

	logic              in_payload_n;
	logic [3:0]        hdr_count_n;
	logic [31:0]       magic_n;
	logic [31:0]       size_n;
	logic [31:0]       exp_n;
	logic [SIZE_W-1:0] idx_n;
	logic [31:0]       sum_n;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = count_q >= QCNT_W'(QUEUE_HIGH);
	assign out_valid = count_q != '0;
	assign pop      = out_valid && !out_stall;

	always_comb begin
		logic [31:0]       merged;
		logic [31:0]       sel_word;
		logic [4:0]        sh;
		logic [SIZE_W-1:0] limit;
		logic              done;

		in_payload_n = in_payload_q;
		hdr_count_n  = hdr_count_q;
		magic_n      = magic_q;
		size_n       = size_q;
		exp_n        = exp_q;
		idx_n        = idx_q;
		sum_n        = sum_q;
		push_cnt     = 2'd0;
		res0         = '0;
		res1         = '0;
		merged       = '0;
		sel_word     = '0;
		sh           = {hdr_count_q[1:0], 3'b000};
		limit        = (max_size_q < MAX_FRAME_BYTES) ? max_size_q : MAX_FRAME_BYTES;
		done         = 1'b0;

		if (valid_s1) begin
			if (!in_payload_q) begin
				case (hdr_count_q[3:2])
					2'd0:    sel_word = magic_q;
					2'd1:    sel_word = size_q;
					default: sel_word = exp_q;
				endcase
				if (hdr_count_q[1:0] == 2'd0) begin
					merged = {24'd0, byte_s1};
				end else begin
					merged = sel_word | ({24'd0, byte_s1} << sh);
				end
				case (hdr_count_q[3:2])
					2'd0:    magic_n = merged;
					2'd1:    size_n  = merged;
					default: exp_n   = merged;
				endcase
				if (hdr_count_q < 4'(HDR_LAST)) begin
					hdr_count_n = hdr_count_q + 4'd1;
				end else begin
					hdr_count_n           = 4'd0;
					res0.kind             = KIND_STATUS;
					res0.frame_size       = size_n;
					res0.expected_sum     = exp_n;
					res0.last             = 1'b1;
					if (magic_n != FRAME_MAGIC) begin
						res0.status = ST_BAD_MAGIC;
						push_cnt    = 2'd1;
					end else if (size_n == 32'd0 || size_n > {7'd0, limit}) begin
						res0.status = ST_BAD_SIZE;
						push_cnt    = 2'd1;
					end else begin
						in_payload_n = 1'b1;
						idx_n        = '0;
						sum_n        = '0;
					end
				end
			end else begin
				sum_n          = sum_q + {24'd0, byte_s1};
				idx_n          = idx_q + SIZE_W'(1);
				done           = {7'd0, idx_n} >= size_q;
				res0.kind      = KIND_WRITE;
				res0.offset    = idx_q[23:0];
				res0.data_byte = byte_s1;
				res0.last      = !done;
				push_cnt       = 2'd1;
				if (done) begin
					in_payload_n      = 1'b0;
					hdr_count_n       = 4'd0;
					res1.kind         = KIND_STATUS;
					res1.status       = (sum_n == exp_q) ? ST_OK : ST_BAD_SUM;
					res1.frame_size   = size_q;
					res1.computed_sum = sum_n;
					res1.expected_sum = exp_q;
					res1.last         = 1'b1;
					push_cnt          = 2'd2;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q   <= MAX_FRAME_BYTES;
			valid_s1     <= 1'b0;
			in_payload_q <= 1'b0;
			hdr_count_q  <= '0;
			magic_q      <= '0;
			size_q       <= '0;
			exp_q        <= '0;
			idx_q        <= '0;
			sum_q        <= '0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			count_q      <= '0;
		end else begin
			if (max_size_we) begin
				max_size_q <= max_size_wdata;
			end
			valid_s1     <= in_acc;
			in_payload_q <= in_payload_n;
			hdr_count_q  <= hdr_count_n;
			magic_q      <= magic_n;
			size_q       <= size_n;
			exp_q        <= exp_n;
			idx_q        <= idx_n;
			sum_q        <= sum_n;
			wr_ptr_q     <= wr_ptr_q + QPTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_cnt) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= rx_byte;
		end
		if (push_cnt != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (push_cnt == 2'd2) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
		end
	end

	always_comb begin
		result_t head;
		head         = queue_q[rd_ptr_q];
		kind         = head.kind;
		offset       = head.offset;
		data_byte    = head.data_byte;
		status       = head.status;
		frame_size   = head.frame_size;
		computed_sum = head.computed_sum;
		expected_sum = head.expected_sum;
		last         = head.last;
	end

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q + QCNT_W'(push_cnt)) <= QCNT_W'(QUEUE_DEPTH))
		else $error("Result queue overflow.");

	a_hdr_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_count_q <= 4'(HDR_LAST))
		else $error("Header byte count out of range.");

	a_payload_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (size_q != 32'd0 && {7'd0, idx_q} < size_q))
		else $error("Payload index beyond declared size.");

	a_payload_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_payload_q && in_payload_n) |=> (idx_q == '0 && sum_q == '0))
		else $error("Payload phase entered without clearing index and sum.");

	a_write_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_WRITE) |-> (status == ST_OK && frame_size == 32'd0))
		else $error("Write request carries status fields.");

endmodule

`default_nettype wire
